// ===== rtl/rkx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkx_pkg
// Shared types and constants for the rotating-key XOR stream cipher.
// ----------------------------------------------------------------------------
package rkx_pkg;

    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_BITS      = 8 * MAX_KEY_BYTES;
    localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int CFG_INDEX_W   = 3;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_WORD_0 = 3'd0,
        CFG_KEY_WORD_1 = 3'd1,
        CFG_KEY_WORD_2 = 3'd2,
        CFG_KEY_WORD_3 = 3'd3,
        CFG_KEY_LENGTH = 3'd4
    } cfg_index_t;

    // Length 0 acts as 1; anything above the key size saturates.
    function automatic logic [KEY_LEN_W-1:0] eff_len(input logic [KEY_LEN_W-1:0] len);
        logic [KEY_LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = KEY_LEN_W'(1);
        end else if (len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            res = KEY_LEN_W'(MAX_KEY_BYTES);
        end
        return res;
    endfunction

endpackage

// ===== rtl/rkx_keystream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkx_keystream
// Working key and key position; gives the key byte for the current item and
// advances on each accepted item, wrapping and rotating the key at chunk end.
// ----------------------------------------------------------------------------
module rkx_keystream
    import rkx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 start,
    input  logic [KEY_BITS-1:0]  cfg_key,   // byte 0 in the top bits
    input  logic [KEY_LEN_W-1:0] key_length,
    output byte_t                key_byte
);

    byte_t                key_reg  [MAX_KEY_BYTES];
    byte_t                key_next [MAX_KEY_BYTES];
    byte_t                src      [MAX_KEY_BYTES];
    logic [KEY_POS_W-1:0] pos_reg;
    logic [KEY_POS_W-1:0] pos_next;
    logic [KEY_POS_W-1:0] pos;
    logic [KEY_LEN_W-1:0] len;
    logic [KEY_LEN_W-1:0] pos_inc;
    logic                 wrap;
    logic                 top_bit;

    always_comb begin
        len     = eff_len(key_length);
        pos     = start ? '0 : pos_reg;
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            src[i] = start ? cfg_key[KEY_BITS-1-8*i -: 8] : key_reg[i];
        end
        key_byte = src[pos];
        pos_inc  = KEY_LEN_W'(pos) + KEY_LEN_W'(1);
        wrap     = pos_inc >= len;
        pos_next = wrap ? '0 : pos_inc[KEY_POS_W-1:0];
        top_bit  = src[0][7];
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            key_next[i] = src[i];
            if (wrap) begin
                if (KEY_LEN_W'(i + 1) == len) begin
                    key_next[i] = {src[i][6:0], top_bit};
                end else if (KEY_LEN_W'(i + 1) < len) begin
                    key_next[i] = {src[i][6:0], src[(i + 1) % MAX_KEY_BYTES][7]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < MAX_KEY_BYTES; i++) begin
                key_reg[i] <= '0;
            end
        end else if (step) begin
            pos_reg <= pos_next;
            for (int i = 0; i < MAX_KEY_BYTES; i++) begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(pos_reg) && $stable(key_reg[0]))
        else $error("key state changed without an item");

    a_start_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        step && start |=> pos_reg <= KEY_POS_W'(1))
        else $error("position not restarted by start flag");

    a_wrap_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        step && wrap |=> pos_reg == '0)
        else $error("position did not wrap at chunk end");

endmodule

// ===== rtl/rotating_key_xor_stream_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotating_key_xor_stream_cipher
// Byte-wide XOR cipher whose key rotates left one bit after every chunk of
// key_length bytes; a start flag reloads the configured key.
//
//  channel  dir  handshake             payload
//  s_axis   in   tvalid/tready         tdata[7:0] data_byte, tuser start_of_stream
//  m_axis   out  tvalid/tready         tdata[7:0] cipher_byte
//  cfg      in   cfg_we                cfg_index, cfg_wdata
//
// One item per cycle while m_axis_tready is high; results are registered.
// Key select, byte mux and rotation are combinational, ahead of the result reg.
// A two-entry output buffer keeps s_axis_tready registered; one extra item is
// taken while a result is stalled.
// Reset (aresetn low, synchronous) clears the key, position and buffer.
// ----------------------------------------------------------------------------
module rotating_key_xor_stream_cipher
    import rkx_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tuser,   // [0] start_of_stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] cipher_byte
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [KEY_WORD_W-1:0]  cfg_wdata
);

    logic [KEY_WORD_W-1:0] key_word_reg [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  key_length_reg;
    logic [KEY_BITS-1:0]   cfg_key;
    byte_t                 key_byte;
    byte_t                 cipher;
    logic                  push;
    logic                  pop;
    logic                  main_valid_reg;
    byte_t                 main_data_reg;
    logic                  skid_valid_reg;
    byte_t                 skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_word_reg[i] <= '0;
            end
            key_length_reg <= KEY_LEN_W'(1);
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_KEY_WORD_0: key_word_reg[0] <= cfg_wdata;
                CFG_KEY_WORD_1: key_word_reg[1] <= cfg_wdata;
                CFG_KEY_WORD_2: key_word_reg[2] <= cfg_wdata;
                CFG_KEY_WORD_3: key_word_reg[3] <= cfg_wdata;
                CFG_KEY_LENGTH: key_length_reg <= cfg_wdata[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_key = {key_word_reg[0], key_word_reg[1], key_word_reg[2], key_word_reg[3]};

    assign s_axis_tready = !skid_valid_reg;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = main_valid_reg && m_axis_tready;

    rkx_keystream u_keystream (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (push),
        .start      (s_axis_tuser),
        .cfg_key    (cfg_key),
        .key_length (key_length_reg),
        .key_byte   (key_byte)
    );

    assign cipher = s_axis_tdata ^ key_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_data_reg  <= skid_data_reg;
                skid_valid_reg <= push;
                if (push) begin
                    skid_data_reg <= cipher;
                end
            end else begin
                main_valid_reg <= push;
                if (push) begin
                    main_data_reg <= cipher;
                end
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_data_reg  <= cipher;
                skid_valid_reg <= 1'b1;
            end else begin
                main_data_reg  <= cipher;
                main_valid_reg <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tdata  = main_data_reg;

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty main entry");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> main_valid_reg)
        else $error("accepted item not buffered");

    a_stall_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && main_valid_reg |=> skid_valid_reg)
        else $error("stalled item lost");

endmodule
